// File: sv/rsm_pkg.sv
// rsm_pkg: shared constants and the operation code type for the range add / range min tree
// depends on nothing; imported by rsm_walker and range_add_range_min_tree_top
package rsm_pkg;

   localparam int LEAF_COUNT_DEF = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam int IDX_BITS       = 11;
   localparam int OPND_BITS      = 32;
   localparam int OUT_BITS       = 32;
   localparam int FUNC_BITS      = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_ADD   = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef struct packed {
      logic done;
      logic empty;
   } stat_type;

endpackage

// File: sv/rsm_node_mem.sv
// rsm_node_mem: node memory of the tree, one word per node holding {minimum, pending add}
// one write port, one read port with registered read data; no package needed
module rsm_node_mem #(
   parameter int ADDR_BITS = 11,
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/rsm_walker.sv
// rsm_walker: clearing sweep and depth-first tree walk that reads, modifies and writes node memory
// depends on rsm_pkg; drives rsm_node_mem ports through the top level
module rsm_walker
   import rsm_pkg::*;
#(
   parameter int LEAF_COUNT = LEAF_COUNT_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [FUNC_BITS-1:0]                  req_func,
   input  logic [IDX_BITS-1:0]                   req_index_lo,
   input  logic [IDX_BITS-1:0]                   req_index_hi,
   input  logic signed [OPND_BITS-1:0]           req_operand,
   output logic                                  mem_we,
   output logic [$clog2(LEAF_COUNT)+1-1:0]       mem_waddr,
   output logic [2*VALUE_BITS-1:0]               mem_wdata,
   output logic [$clog2(LEAF_COUNT)+1-1:0]       mem_raddr,
   input  logic [2*VALUE_BITS-1:0]               mem_rdata,
   output stat_type                              stat,
   output logic signed [VALUE_BITS-1:0]          value
);

   localparam int VW  = VALUE_BITS;
   localparam int LG  = $clog2(LEAF_COUNT);
   localparam int AW  = LG + 1;
   localparam int DW  = $clog2(LG + 1);
   localparam int CW  = (LG + 1 > IDX_BITS) ? LG + 1 : IDX_BITS;
   localparam int XW  = (VW > OPND_BITS) ? VW : OPND_BITS;

   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic [AW-1:0] ONE_AW  = AW'(1);
   localparam logic [AW-1:0] ROOT    = AW'(1);
   localparam logic [AW-1:0] LAST_AW = {AW{1'b1}};
   localparam logic [CW-1:0] ONE_CW  = CW'(1);
   localparam logic [CW-1:0] LC_CW   = CW'(LEAF_COUNT);
   localparam logic [DW-1:0] LG_DW   = DW'(LG);
   localparam logic [DW-1:0] ONE_DW  = DW'(1);

   typedef enum logic [9:0] {
      S_CLR   = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_VISIT = 10'b0000000100,
      S_HD1   = 10'b0000001000,
      S_HD2   = 10'b0000010000,
      S_HD3   = 10'b0000100000,
      S_COV   = 10'b0001000000,
      S_RET   = 10'b0010000000,
      S_RC1   = 10'b0100000000,
      S_RC2   = 10'b1000000000
   } state_type;

   function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
      logic signed [VW:0] s;
      s = (VW+1)'(a) + (VW+1)'(b);
      if (s[VW] != s[VW-1]) begin
         sat_add = s[VW] ? VMIN : VMAX;
      end else begin
         sat_add = s[VW-1:0];
      end
   endfunction

   state_type              state_ff, state_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [DW-1:0]          d_ff, d_in;
   logic [CW-1:0]          lo_ff, lo_in, hi_ff, hi_in;
   func_type               op_ff, op_in;
   logic signed [VW-1:0]   x_ff, x_in;
   logic signed [VW-1:0]   p_ff, p_in;
   logic signed [VW-1:0]   lmin_ff, lmin_in;
   logic signed [VW-1:0]   acc_ff, acc_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   done_ff, done_in, empty_ff, empty_in;

   logic [CW-1:0]          lo_c, hi_c, lo_ext, hi_ext;
   logic signed [XW-1:0]   opx;
   logic signed [VW-1:0]   opv;
   logic [AW-1:0]          k_off;
   logic [DW-1:0]          sh;
   logic [CW-1:0]          span_l, span_r;
   logic                   disjoint, covered;
   logic signed [VW-1:0]   rd_min, rd_pend;

   assign rd_min  = mem_rdata[2*VW-1:VW];
   assign rd_pend = mem_rdata[VW-1:0];

   always_comb begin
      lo_ext = CW'(req_index_lo);
      hi_ext = CW'(req_index_hi);
      lo_c   = (lo_ext > LC_CW) ? LC_CW : lo_ext;
      hi_c   = (hi_ext > LC_CW) ? LC_CW : hi_ext;
      opx    = XW'(req_operand);
      if (opx > XW'(VMAX)) begin
         opv = VMAX;
      end else if (opx < XW'(VMIN)) begin
         opv = VMIN;
      end else begin
         opv = VW'(opx);
      end
      k_off    = k_ff & ~(ONE_AW << d_ff);
      sh       = LG_DW - d_ff;
      span_l   = CW'(k_off) << sh;
      span_r   = span_l + (ONE_CW << sh);
      disjoint = (span_l >= hi_ff) || (lo_ff >= span_r);
      covered  = (span_l >= lo_ff) && (span_r <= hi_ff);
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      d_in      = d_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      p_in      = p_ff;
      lmin_in   = lmin_ff;
      acc_in    = acc_ff;
      clr_in    = clr_ff;
      done_in   = 1'b0;
      empty_in  = empty_ff;
      mem_we    = 1'b0;
      mem_waddr = k_ff;
      mem_wdata = {rd_min, VW'(0)};
      mem_raddr = k_ff;
      case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = {VMAX, VW'(0)};
            clr_in    = clr_ff + ONE_AW;
            if (clr_ff == LAST_AW) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = func_type'(req_func);
               x_in  = opv;
               k_in  = ROOT;
               d_in  = '0;
               lo_in = lo_c;
               hi_in = hi_c;
               case (req_func)
                  FUNC_LOAD: begin
                     hi_in = lo_c + ONE_CW;
                     if (lo_ext < LC_CW) begin
                        state_in = S_VISIT;
                     end
                  end
                  FUNC_ADD: begin
                     if (lo_c < hi_c) begin
                        state_in = S_VISIT;
                     end
                  end
                  FUNC_QUERY: begin
                     acc_in = VMAX;
                     if (lo_c < hi_c) begin
                        state_in = S_VISIT;
                        empty_in = 1'b0;
                     end else begin
                        done_in  = 1'b1;
                        empty_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_VISIT: begin
            if (disjoint) begin
               state_in = S_RET;
            end else if (covered) begin
               if (op_ff == FUNC_LOAD) begin
                  mem_we    = 1'b1;
                  mem_wdata = {x_ff, VW'(0)};
                  state_in  = S_RET;
               end else begin
                  state_in = S_COV;
               end
            end else begin
               state_in = S_HD1;
            end
         end
         S_HD1: begin
            p_in      = rd_pend;
            mem_we    = 1'b1;
            mem_wdata = {rd_min, VW'(0)};
            mem_raddr = {k_ff[AW-2:0], 1'b0};
            state_in  = S_HD2;
         end
         S_HD2: begin
            mem_we    = 1'b1;
            mem_waddr = {k_ff[AW-2:0], 1'b0};
            mem_wdata = {sat_add(rd_min, p_ff), sat_add(rd_pend, p_ff)};
            mem_raddr = {k_ff[AW-2:0], 1'b1};
            state_in  = S_HD3;
         end
         S_HD3: begin
            mem_we    = 1'b1;
            mem_waddr = {k_ff[AW-2:0], 1'b1};
            mem_wdata = {sat_add(rd_min, p_ff), sat_add(rd_pend, p_ff)};
            k_in      = {k_ff[AW-2:0], 1'b0};
            d_in      = d_ff + ONE_DW;
            state_in  = S_VISIT;
         end
         S_COV: begin
            if (op_ff == FUNC_QUERY) begin
               if (rd_min < acc_ff) begin
                  acc_in = rd_min;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {sat_add(rd_min, x_ff), sat_add(rd_pend, x_ff)};
            end
            state_in = S_RET;
         end
         S_RET: begin
            mem_raddr = k_ff - ONE_AW;
            if (k_ff == ROOT) begin
               state_in = S_IDLE;
               done_in  = (op_ff == FUNC_QUERY);
            end else if (!k_ff[0]) begin
               k_in     = k_ff + ONE_AW;
               state_in = S_VISIT;
            end else begin
               k_in = k_ff >> 1;
               d_in = d_ff - ONE_DW;
               if (op_ff != FUNC_QUERY) begin
                  state_in = S_RC1;
               end
            end
         end
         S_RC1: begin
            lmin_in   = rd_min;
            mem_raddr = {k_ff[AW-2:0], 1'b1};
            state_in  = S_RC2;
         end
         S_RC2: begin
            mem_we    = 1'b1;
            mem_wdata = {((rd_min < lmin_ff) ? rd_min : lmin_ff), VW'(0)};
            state_in  = S_RET;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         done_ff  <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         done_ff  <= done_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      d_ff    <= d_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      op_ff   <= op_in;
      x_ff    <= x_in;
      p_ff    <= p_in;
      lmin_ff <= lmin_in;
      acc_ff  <= acc_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign stat.done  = done_ff;
   assign stat.empty = empty_ff;
   assign value      = acc_ff;

endmodule

// File: sv/range_add_range_min_tree_top.sv
// range_add_range_min_tree_top: lazy segment tree with point load, range add and range minimum query
// depends on rsm_pkg, rsm_node_mem and rsm_walker
//
//   channel   ports                                            beat taken when
//   request   start busy req_func req_index_lo/hi req_operand  start high, busy low
//   response  rsp_valid rsp_min_value rsp_range_empty          rsp_valid high, one cycle
//
// one item at a time; busy stays high while the walk runs
// a walk visits up to four nodes per level; its length is set by the single read and write
// port of node memory; the response strobe is registered through the walker's done flag
// and then rsp_valid, after the walk's last state or after the accepting edge of an
// empty query
// after reset a clearing sweep writes {maximum, 0} to every node word and holds busy high
// out-of-range loads, empty adds, empty queries and unused codes never raise busy
// no response stall exists
module range_add_range_min_tree_top
   import rsm_pkg::*;
#(
   parameter int LEAF_COUNT = LEAF_COUNT_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [FUNC_BITS-1:0]        req_func,
   input  logic [IDX_BITS-1:0]         req_index_lo,
   input  logic [IDX_BITS-1:0]         req_index_hi,
   input  logic signed [OPND_BITS-1:0] req_operand,
   output logic                        rsp_valid,
   output logic signed [OUT_BITS-1:0]  rsp_min_value,
   output logic                        rsp_range_empty
);

   localparam int VW = VALUE_BITS;
   localparam int AW = $clog2(LEAF_COUNT) + 1;
   localparam int YW = (VW > OUT_BITS) ? VW : OUT_BITS;
   localparam logic signed [OUT_BITS-1:0] OMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr, mem_raddr;
   logic [2*VW-1:0]             mem_wdata, mem_rdata;
   stat_type                    stat;
   logic signed [VW-1:0]        value;
   logic signed [YW-1:0]        value_x;
   logic signed [OUT_BITS-1:0]  value_c;
   logic                        valid_ff;
   logic signed [OUT_BITS-1:0]  min_ff;
   logic                        empty_ff;

   rsm_node_mem #(
      .ADDR_BITS(AW),
      .DATA_BITS(2*VW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rsm_walker #(
      .LEAF_COUNT(LEAF_COUNT),
      .VALUE_BITS(VALUE_BITS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_index_lo (req_index_lo),
      .req_index_hi (req_index_hi),
      .req_operand  (req_operand),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .stat         (stat),
      .value        (value)
   );

   always_comb begin
      value_x = YW'(value);
      if (value_x > YW'(OMAX)) begin
         value_c = OMAX;
      end else if (value_x < YW'(OMIN)) begin
         value_c = OMIN;
      end else begin
         value_c = OUT_BITS'(value_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stat.done;
      end
   end

   always_ff @(posedge clock) begin
      min_ff   <= value_c;
      empty_ff <= stat.empty;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_min_value   = min_ff;
   assign rsp_range_empty = empty_ff;

endmodule

// File: test/tb_top.sv
// tb_top: self-checking bench for range_add_range_min_tree_top (range add / range min tree)
// depends on rsm_pkg and the block's RTL; directed table first, then random beats,
// every query answer checked against an in-bench lazy segment tree model
module tb_top;
   import rsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LEAVES = 1024;
   localparam int  SPAN   = 1024;
   localparam int  SLOTS  = 4 * LEAVES;
   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] min_value;
      logic               range_empty;
   } answer_t;

   typedef struct {
      logic [FUNC_BITS-1:0] func;
      logic [10:0]        lo;
      logic [10:0]        hi;
      logic signed [31:0] operand;
      bit                 typed;
      logic signed [31:0] min_value;
      logic               range_empty;
   } row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FUNC_BITS-1:0] req_func = '0;
   logic [IDX_BITS-1:0]  req_index_lo = '0;
   logic [IDX_BITS-1:0]  req_index_hi = '0;
   logic signed [OPND_BITS-1:0] req_operand = '0;
   logic                 rsp_valid;
   logic signed [OUT_BITS-1:0] rsp_min_value;
   logic                 rsp_range_empty;

   longint tree_min [SLOTS];
   longint tree_tag [SLOTS];
   bit     tree_flag[SLOTS];
   answer_t pending_answers[$];
   int     fail_count = 0;
   int     query_count = 0;
   int     beat_count = 0;
   bit     quiet = 1'b0;

   range_add_range_min_tree_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_index_lo(req_index_lo), .req_index_hi(req_index_hi),
      .req_operand(req_operand), .rsp_valid(rsp_valid), .rsp_min_value(rsp_min_value),
      .rsp_range_empty(rsp_range_empty)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint sat_sum(longint a, longint b);
      longint s = a + b;
      if (s > VMAX) return VMAX;
      if (s < VMIN) return VMIN;
      return s;
   endfunction

   function automatic void tag_node(int k, longint x);
      if (k >= SLOTS) return;
      tree_flag[k] = 1'b1;
      tree_min[k] = sat_sum(tree_min[k], x);
      tree_tag[k] = sat_sum(tree_tag[k], x);
   endfunction

   function automatic void push_tag(int k);
      if (k >= SLOTS || !tree_flag[k]) return;
      tree_flag[k] = 1'b0;
      tag_node(2 * k, tree_tag[k]);
      tag_node(2 * k + 1, tree_tag[k]);
      tree_tag[k] = 0;
   endfunction

   function automatic void refresh_node(int k);
      if (2 * k + 1 >= SLOTS) return;
      tree_min[k] = (tree_min[2*k] < tree_min[2*k+1]) ? tree_min[2*k] : tree_min[2*k+1];
   endfunction

   function automatic longint seg_min(int l, int r, int ql, int qr, int k);
      int m;
      longint a, b;
      if (l >= qr || ql >= r || k >= SLOTS) return VMAX;
      if (l >= ql && r <= qr) return tree_min[k];
      push_tag(k);
      m = (l + r) / 2;
      a = seg_min(l, m, ql, qr, 2 * k);
      b = seg_min(m, r, ql, qr, 2 * k + 1);
      return (a < b) ? a : b;
   endfunction

   function automatic void seg_add(int l, int r, int ql, int qr, int k, longint x);
      int m;
      if (l >= qr || ql >= r || k >= SLOTS) return;
      if (l >= ql && r <= qr) begin
         tag_node(k, x);
         return;
      end
      push_tag(k);
      m = (l + r) / 2;
      seg_add(l, m, ql, qr, 2 * k, x);
      seg_add(m, r, ql, qr, 2 * k + 1, x);
      refresh_node(k);
   endfunction

   function automatic void leaf_load(int e, longint v);
      int k = 1, l = 0, r = SPAN, m;
      while (r - l > 1) begin
         push_tag(k);
         m = (l + r) / 2;
         if (e < m) begin
            r = m;
            k = 2 * k;
         end else begin
            l = m;
            k = 2 * k + 1;
         end
      end
      tree_min[k] = v;
      tree_tag[k] = 0;
      tree_flag[k] = 1'b0;
      k = k >> 1;
      while (k >= 1) begin
         refresh_node(k);
         k = k >> 1;
      end
   endfunction

   // returns 1 when the beat produces an answer
   function automatic bit predict_beat(logic [1:0] f, int lo, int hi, longint opv,
                                       output answer_t ans);
      longint m;
      ans.min_value = '0;
      ans.range_empty = 1'b0;
      if (f == FUNC_LOAD) begin
         if (lo < LEAVES) leaf_load(lo, opv);
         return 1'b0;
      end
      if (lo > LEAVES) lo = LEAVES;
      if (hi > LEAVES) hi = LEAVES;
      if (f == FUNC_ADD) begin
         if (lo < hi) seg_add(0, SPAN, lo, hi, 1, opv);
         return 1'b0;
      end
      if (f == FUNC_QUERY) begin
         if (lo >= hi) begin
            m = VMAX;
            ans.range_empty = 1'b1;
         end else begin
            m = seg_min(0, SPAN, lo, hi, 1);
         end
         ans.min_value = m[31:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic send_beat(logic [1:0] f, logic [10:0] lo, logic [10:0] hi,
                            logic signed [31:0] op, output bit got, output answer_t ans);
      if (!quiet && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_index_lo <= lo;
      req_index_hi <= hi;
      req_operand <= op;
      do @(posedge clock); while (busy);
      got = predict_beat(f, int'(lo), int'(hi), longint'(op), ans);
      beat_count++;
      if (got) begin
         pending_answers.push_back(ans);
         query_count++;
      end
   endtask

   always @(posedge clock) begin
      answer_t exp_ans;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer min=%0d empty=%0b", $time, rsp_min_value,
                     rsp_range_empty);
            fail_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_min_value !== exp_ans.min_value) begin
               $display("%0t: min_value expected %0d actual %0d", $time,
                        exp_ans.min_value, rsp_min_value);
               fail_count++;
            end
            if (rsp_range_empty !== exp_ans.range_empty) begin
               $display("%0t: range_empty expected %0b actual %0b", $time,
                        exp_ans.range_empty, rsp_range_empty);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("FAIL range_add_range_min_tree_top");
      $finish;
   end

   initial begin
      row_t    rows[$];
      answer_t ans;
      bit      got;
      int      pick, i, step_len;
      logic [10:0] lo, hi;
      logic signed [31:0] op;
      logic [1:0] f;

      for (i = 0; i < SLOTS; i++) begin
         tree_min[i] = VMAX;
         tree_tag[i] = 0;
         tree_flag[i] = 1'b0;
      end
      rows = '{
         '{FUNC_QUERY, 11'd0, 11'd1024, 32'sd0, 1'b1, 32'sh7fffffff, 1'b0},
         '{FUNC_QUERY, 11'd5, 11'd5, 32'sd0, 1'b1, 32'sh7fffffff, 1'b1},
         '{FUNC_QUERY, 11'd900, 11'd3, 32'sd0, 1'b1, 32'sh7fffffff, 1'b1},
         '{FUNC_LOAD, 11'd0, 11'd0, 32'sh80000000, 1'b0, 32'sd0, 1'b0},
         '{FUNC_LOAD, 11'd1023, 11'd0, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
         '{FUNC_LOAD, 11'd1024, 11'd0, -32'sd7, 1'b0, 32'sd0, 1'b0},
         '{FUNC_LOAD, 11'd2047, 11'd0, -32'sd9, 1'b0, 32'sd0, 1'b0},
         '{FUNC_QUERY, 11'd0, 11'd2047, 32'sd0, 1'b1, 32'sh80000000, 1'b0},
         '{FUNC_QUERY, 11'd1, 11'd1024, 32'sd0, 1'b1, 32'sh7fffffff, 1'b0},
         '{FUNC_ADD, 11'd0, 11'd2047, 32'sh80000000, 1'b0, 32'sd0, 1'b0},
         '{FUNC_QUERY, 11'd0, 11'd1, 32'sd0, 1'b1, 32'sh80000000, 1'b0},
         '{FUNC_ADD, 11'd0, 11'd1024, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
         '{FUNC_QUERY, 11'd0, 11'd1024, 32'sd0, 1'b0, 32'sd0, 1'b0},
         '{FUNC_LOAD, 11'd512, 11'd0, 32'sd100, 1'b0, 32'sd0, 1'b0},
         '{FUNC_ADD, 11'd500, 11'd520, -32'sd250, 1'b0, 32'sd0, 1'b0},
         '{FUNC_ADD, 11'd600, 11'd400, 32'sd1, 1'b0, 32'sd0, 1'b0},
         '{2'd3, 11'd0, 11'd1024, 32'sd5, 1'b0, 32'sd0, 1'b0},
         '{FUNC_QUERY, 11'd511, 11'd513, 32'sd0, 1'b0, 32'sd0, 1'b0},
         '{FUNC_QUERY, 11'd1024, 11'd2047, 32'sd0, 1'b1, 32'sh7fffffff, 1'b1},
         '{FUNC_QUERY, 11'd1023, 11'd1024, 32'sd0, 1'b0, 32'sd0, 1'b0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         send_beat(rows[r].func, rows[r].lo, rows[r].hi, rows[r].operand, got, ans);
         if (rows[r].typed && (ans.min_value !== rows[r].min_value ||
                               ans.range_empty !== rows[r].range_empty)) begin
            $display("%0t: row %0d expected %0d/%0b model gives %0d/%0b", $time, r,
                     rows[r].min_value, rows[r].range_empty, ans.min_value, ans.range_empty);
            fail_count++;
         end
      end

      for (i = 0; i < 600; i++) begin
         quiet = (i >= 250 && i < 350);
         pick = $urandom_range(99);
         if (pick < 30) f = FUNC_LOAD;
         else if (pick < 60) f = FUNC_ADD;
         else if (pick < 96) f = FUNC_QUERY;
         else f = 2'd3;
         pick = $urandom_range(99);
         if (pick < 85) begin
            lo = 11'($urandom_range(1023));
            step_len = int'($urandom_range(1, 64));
            hi = (int'(lo) + step_len > 1024) ? 11'd1024 : 11'(int'(lo) + step_len);
         end else begin
            lo = 11'($urandom_range(2047));
            hi = 11'($urandom_range(2047));
         end
         pick = $urandom_range(99);
         if (pick < 10) op = 32'sh7fffffff;
         else if (pick < 20) op = 32'sh80000000;
         else if (pick < 60) op = $urandom;
         else op = $signed($urandom_range(2000)) - 1000;
         send_beat(f, lo, hi, op, got, ans);
      end
      start <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("ran %0d beats, %0d queries, with saturation, empty and out-of-range cases",
               beat_count, query_count);
      if (fail_count == 0 && pending_answers.size() == 0)
         $display("PASS range_add_range_min_tree_top");
      else
         $display("FAIL range_add_range_min_tree_top");
      $finish;
   end

endmodule
